@@ sv/f2fx_pkg.sv @@
// Shared types, constants and functions for the float32 to fixed 17.14 converter
`default_nettype none
package f2fx_pkg;

	localparam logic [2:0] MODE_RNE = 3'd0;
	localparam logic [2:0] MODE_RTZ = 3'd1;
	localparam logic [2:0] MODE_RDN = 3'd2;
	localparam logic [2:0] MODE_RUP = 3'd3;
	localparam logic [2:0] MODE_RMM = 3'd4;

	localparam logic [7:0]  EXP_ALL    = 8'hff;
	localparam logic [30:0] BIG_LIMIT  = 31'h78800000;
	localparam logic [7:0]  EXP_SPLIT  = 8'd112;
	localparam logic [8:0]  EBASE_HALF = 9'd134;
	localparam logic [8:0]  EBASE_OFS  = 9'd22;
	localparam logic [8:0]  BE_INF     = 9'd255;
	localparam logic [8:0]  BE_INT     = 9'd170;
	localparam logic [63:0] HALF_SIG   = 64'h0080_0000_0000_0000;
	localparam logic [31:0] SAT_POS    = 32'h7fffffff;
	localparam logic [31:0] SAT_NEG    = 32'h80000000;

	typedef struct packed {
		logic [31:0] float_bits;
		logic [2:0]  rounding_mode;
	} in_t;

	typedef struct packed {
		logic signed [31:0] fixed_value;
		logic               flag_invalid;
		logic               flag_inexact;
		logic               flag_denormal;
		logic               flag_overflow;
	} out_t;

	typedef struct packed {
		logic inv;
		logic inx;
		logic den;
		logic ovf;
	} flags_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [63:0] a;
		logic [63:0] b;
		logic [8:0]  ebase;
	} s1_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [63:0] r;
		logic [8:0]  ebase;
	} s2_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [63:0] r;
		logic [8:0]  ebase;
		logic [5:0]  lz;
	} s3_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [63:0] rn;
		logic [8:0]  be;
	} s4_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [23:0] sig;
		logic [8:0]  be;
	} s5_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic [2:0]  mode;
		logic [63:0] s;
	} s6_t;

	typedef struct packed {
		logic        byp;
		flags_t      fl;
		logic        neg;
		logic        bad;
		logic [31:0] q;
	} s7_t;

	function automatic logic [63:0] jam64(input logic [63:0] v, input logic [7:0] d);
		logic [63:0] m;
		m = ~({64{1'b1}} << d[5:0]);
		if (d >= 8'd63) begin
			return {63'd0, |v};
		end
		return (v >> d[5:0]) | {63'd0, |(v & m)};
	endfunction

endpackage
`default_nettype wire

@@ sv/f2fx_align.sv @@
// Decode, operand alignment and add of one half
`default_nettype none
module f2fx_align (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire f2fx_pkg::in_t   din,
	output logic                 vout,
	output f2fx_pkg::s2_t        dout
);
	import f2fx_pkg::*;

	logic  v_s1;
	s1_t   d_s1;
	s1_t   n1;
	s2_t   n2;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [7:0]  sh;
	logic [63:0] mant;
	logic        gt;

	always_comb begin
		ex = din.float_bits[30:23];
		fr = din.float_bits[22:0];
		mant = {8'd0, 1'b1, fr, 32'd0};
		n1 = '0;
		n1.neg = din.float_bits[31];
		n1.mode = din.rounding_mode;
		sh = 8'd0;
		if (ex == EXP_ALL && fr != 23'd0) begin
			n1.byp = 1'b1;
			n1.fl.inv = ~fr[22];
		end else if (ex == 8'd0) begin
			n1.byp = 1'b1;
			n1.fl.den = (din.float_bits != 32'd0);
		end else if (din.float_bits[30:0] >= BIG_LIMIT) begin
			n1.byp = 1'b1;
			n1.fl.inx = 1'b1;
		end
		if (ex >= EXP_SPLIT) begin
			sh = ex - EXP_SPLIT;
			n1.a = mant;
			n1.b = jam64(HALF_SIG, sh);
			n1.ebase = {1'b0, ex} + EBASE_OFS;
		end else begin
			sh = EXP_SPLIT - ex;
			n1.a = jam64(mant, sh);
			n1.b = HALF_SIG;
			n1.ebase = EBASE_HALF;
		end
	end

	always_comb begin
		gt = d_s1.a > d_s1.b;
		n2.byp = d_s1.byp;
		n2.fl = d_s1.fl;
		n2.mode = d_s1.mode;
		n2.ebase = d_s1.ebase;
		n2.neg = 1'b0;
		if (!d_s1.neg) begin
			n2.r = d_s1.a + d_s1.b;
		end else if (gt) begin
			n2.r = d_s1.a - d_s1.b;
			n2.neg = 1'b1;
		end else begin
			n2.r = d_s1.b - d_s1.a;
		end
		if (n2.r == 64'd0) begin
			n2.byp = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= n1;
			dout <= n2;
		end
	end

endmodule
`default_nettype wire

@@ sv/f2fx_norm.sv @@
// Leading zero count, normalisation and single-precision rounding
`default_nettype none
module f2fx_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire f2fx_pkg::s2_t   din,
	output logic                 vout,
	output f2fx_pkg::s5_t        dout
);
	import f2fx_pkg::*;

	logic  v_s3, v_s4;
	s3_t   d_s3, n3;
	s4_t   d_s4, n4;
	s5_t   n5;
	logic [39:0] rem;
	logic        any, above, tie, up;
	logic [24:0] inc;

	always_comb begin
		n3.byp = din.byp;
		n3.fl = din.fl;
		n3.neg = din.neg;
		n3.mode = din.mode;
		n3.r = din.r;
		n3.ebase = din.ebase;
		n3.lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (din.r[i]) begin
				n3.lz = 6'(63 - i);
			end
		end
	end

	always_comb begin
		n4.byp = d_s3.byp;
		n4.fl = d_s3.fl;
		n4.neg = d_s3.neg;
		n4.mode = d_s3.mode;
		n4.rn = d_s3.r << d_s3.lz;
		n4.be = d_s3.ebase - {3'd0, d_s3.lz};
	end

	always_comb begin
		rem = d_s4.rn[39:0];
		any = |rem;
		above = rem[39] & (|rem[38:0]);
		tie = rem[39] & ~(|rem[38:0]);
		case (d_s4.mode)
			MODE_RNE: up = above | (tie & d_s4.rn[40]);
			MODE_RMM: up = above | tie;
			MODE_RDN: up = d_s4.neg & any;
			MODE_RUP: up = ~d_s4.neg & any;
			MODE_RTZ: up = 1'b0;
			default:  up = 1'b0;
		endcase
		inc = {1'b0, d_s4.rn[63:40]} + {24'd0, up};
		n5.byp = d_s4.byp;
		n5.fl = d_s4.fl;
		n5.neg = d_s4.neg;
		n5.mode = d_s4.mode;
		n5.sig = inc[23:0];
		n5.be = d_s4.be;
		if (inc[24]) begin
			n5.sig = 24'h800000;
			n5.be = d_s4.be + 9'd1;
		end
		if (!d_s4.byp) begin
			n5.fl.inx = any;
			if (n5.be >= BE_INF) begin
				n5.byp = 1'b1;
				n5.fl.inv = 1'b1;
				n5.fl.inx = 1'b1;
				n5.fl.ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s3 <= vin;
			v_s4 <= v_s3;
			vout <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= n3;
			d_s4 <= n4;
			dout <= n5;
		end
	end

endmodule
`default_nettype wire

@@ sv/f2fx_toint.sv @@
// Integer conversion with rounding, saturation and final result
`default_nettype none
module f2fx_toint (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire f2fx_pkg::s5_t   din,
	output logic                 vout,
	output f2fx_pkg::out_t       dout
);
	import f2fx_pkg::*;

	logic  v_s6, v_s7;
	s6_t   d_s6, n6;
	s7_t   d_s7, n7;
	out_t  n8;
	logic [7:0]  rshift;
	logic [63:0] sum;
	logic [11:0] rb;
	logic [11:0] inc;
	logic [31:0] sat;

	always_comb begin
		rshift = (din.be < BE_INT) ? 8'(BE_INT - din.be) : 8'd0;
		n6.byp = din.byp;
		n6.fl = din.fl;
		n6.neg = din.neg;
		n6.mode = din.mode;
		n6.s = jam64({8'd0, din.sig, 32'd0}, rshift);
	end

	always_comb begin
		case (d_s6.mode)
			MODE_RNE: inc = 12'h800;
			MODE_RMM: inc = 12'h800;
			MODE_RDN: inc = d_s6.neg ? 12'hfff : 12'h000;
			MODE_RUP: inc = d_s6.neg ? 12'h000 : 12'hfff;
			MODE_RTZ: inc = 12'h000;
			default:  inc = 12'h000;
		endcase
		rb = d_s6.s[11:0];
		sum = d_s6.s + {52'd0, inc};
		n7.byp = d_s6.byp;
		n7.fl = d_s6.fl;
		n7.neg = d_s6.neg;
		n7.q = sum[43:12];
		if (rb == 12'h800 && d_s6.mode == MODE_RNE) begin
			n7.q[0] = 1'b0;
		end
		n7.bad = (|sum[63:44]) ||
			(d_s6.neg ? (n7.q > SAT_NEG) : (n7.q > SAT_POS));
		if (!d_s6.byp && !n7.bad && rb != 12'd0) begin
			n7.fl.inx = 1'b1;
		end
	end

	always_comb begin
		sat = d_s7.neg ? SAT_NEG : SAT_POS;
		n8.flag_invalid = d_s7.fl.inv;
		n8.flag_inexact = d_s7.fl.inx;
		n8.flag_denormal = d_s7.fl.den;
		n8.flag_overflow = d_s7.fl.ovf;
		if (d_s7.byp) begin
			n8.fixed_value = d_s7.fl.ovf ? sat : 32'd0;
		end else if (d_s7.bad) begin
			n8.fixed_value = sat;
			n8.flag_invalid = 1'b1;
		end else begin
			n8.fixed_value = d_s7.neg ? (32'd0 - d_s7.q) : d_s7.q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s6 <= vin;
			v_s7 <= v_s6;
			vout <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6 <= n6;
			d_s7 <= n7;
			dout <= n8;
		end
	end

endmodule
`default_nettype wire

@@ sv/float32_to_fixed_17_14_core.sv @@
// An accepted request passes through the stages in order to its result on the output register.
// Throughput: one request per cycle; eight register stages run in lockstep.
// A result held on the output stalls all stages together; nothing is lost or repeated.
// Reset: arst_n clears every stage valid bit; payload registers are not reset.
`default_nettype none
module float32_to_fixed_17_14_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire f2fx_pkg::in_t   req_data,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output f2fx_pkg::out_t       res_data
);
	import f2fx_pkg::*;

	logic  en;
	logic  v2, v5;
	s2_t   d2;
	s5_t   d5;

	assign en = ~res_valid | res_ready;
	assign req_ready = en;

	f2fx_align u_align (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(req_valid), .din(req_data), .vout(v2), .dout(d2)
	);

	f2fx_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v2), .din(d2), .vout(v5), .dout(d5)
	);

	f2fx_toint u_toint (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v5), .din(d5), .vout(res_valid), .dout(res_data)
	);

endmodule
`default_nettype wire
